[design/bmhq_pkg.sv]
// Shared types and constants for the binary min-heap priority queue.
package bmhq_pkg;

   localparam int HEAP_DEPTH_DEF = 64;
   localparam int VALUE_W        = 32;
   localparam int STATUS_W       = 2;
   localparam int CMDQ_DEPTH     = 4;

   typedef enum logic {
      OP_PUSH = 1'b0,
      OP_POP  = 1'b1
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE  = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_UP_RD,
      S_UP_CMP,
      S_LAST_RD,
      S_DN_RD,
      S_DN_CMP,
      S_FINISH
   } eng_state_type;

   typedef struct packed {
      op_type                     op;
      logic signed [VALUE_W-1:0]  value;
   } cmd_type;

endpackage

[design/binary_min_heap_queue_top.sv]
// Top level of the binary min-heap priority queue.
// Signed 32-bit priority queue kept as a binary min-heap of up to HEAP_DEPTH
// entries. Each request transfer (tuser 0 push, 1 pop) yields one response
// transfer with status, the minimum after the operation (zero when empty),
// the entry count and an empty flag. In the heap engine, the sift loop uses a heap
// memory read state and a compare and write-back state for each level. Rejected
// operations and a pop that empties the heap go straight to the finish state. A
// short command queue lets requests be taken while the engine works and while a
// response waits. The heap memory needs no clearing after reset.
module binary_min_heap_queue_top
   import bmhq_pkg::*;
#(
   parameter int HEAP_DEPTH = HEAP_DEPTH_DEF,
   parameter int CNT_W      = $clog2(HEAP_DEPTH + 1),
   parameter int OUT_W      = ((VALUE_W + STATUS_W + CNT_W + 1 + 7) / 8) * 8
)
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [VALUE_W-1:0] req_tdata,   // value[31:0]
   input  logic               req_tuser,   // operation[0]
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [OUT_W-1:0]   rsp_tdata    // status, min_value, entry_count, heap_empty
);

   logic    fe_valid, fe_ready;
   cmd_type fe_cmd;
   logic    q_valid, q_ready;
   cmd_type q_cmd;

   bmhq_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd_valid  (fe_valid),
      .cmd_ready  (fe_ready),
      .cmd        (fe_cmd)
   );

   bmhq_cmd_fifo u_cmd_fifo (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fe_valid),
      .in_ready  (fe_ready),
      .in_cmd    (fe_cmd),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_cmd   (q_cmd)
   );

   bmhq_engine #(
      .HEAP_DEPTH (HEAP_DEPTH),
      .CNT_W      (CNT_W),
      .OUT_W      (OUT_W)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (q_valid),
      .cmd_ready  (q_ready),
      .cmd        (q_cmd),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

[design/bmhq_front.sv]
// Input stage: registers a transfer and decodes it into a heap command.
module bmhq_front
   import bmhq_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [VALUE_W-1:0]  req_tdata,   // value[31:0]
   input  logic                req_tuser,   // operation[0]
   output logic                cmd_valid,
   input  logic                cmd_ready,
   output cmd_type             cmd
);

   logic    valid_ff, valid_in;
   cmd_type cmd_ff, cmd_in;

   assign req_tready = !valid_ff || cmd_ready;
   assign cmd_valid  = valid_ff;
   assign cmd        = cmd_ff;

   always_comb begin
      valid_in = valid_ff;
      cmd_in   = cmd_ff;
      if (cmd_ready) begin
         valid_in = 1'b0;
      end
      if (req_tvalid && req_tready) begin
         valid_in     = 1'b1;
         cmd_in.op    = req_tuser ? OP_POP : OP_PUSH;
         cmd_in.value = req_tdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      cmd_ff <= cmd_in;
   end

endmodule

[design/bmhq_cmd_fifo.sv]
// Short command queue between the input stage and the heap engine.
module bmhq_cmd_fifo
   import bmhq_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  cmd_type  in_cmd,
   output logic     out_valid,
   input  logic     out_ready,
   output cmd_type  out_cmd
);

   localparam int PTR_W = $clog2(CMDQ_DEPTH);
   localparam int CNT_W = $clog2(CMDQ_DEPTH + 1);

   cmd_type          slot_ff [CMDQ_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             push, pop;

   assign in_ready  = cnt_ff != CNT_W'(CMDQ_DEPTH);
   assign out_valid = cnt_ff != '0;
   assign out_cmd   = slot_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = push ? PTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop  ? PTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push && !pop) begin
         cnt_in = CNT_W'(cnt_ff + 1'b1);
      end else if (pop && !push) begin
         cnt_in = CNT_W'(cnt_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_cmd;
      end
   end

endmodule

[design/bmhq_engine.sv]
// Heap engine: heap memory, sift-up/sift-down sequencer and result register.
module bmhq_engine
   import bmhq_pkg::*;
#(
   parameter int HEAP_DEPTH = HEAP_DEPTH_DEF,
   parameter int CNT_W      = $clog2(HEAP_DEPTH + 1),
   parameter int OUT_W      = ((VALUE_W + STATUS_W + CNT_W + 1 + 7) / 8) * 8
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   output logic              cmd_ready,
   input  cmd_type           cmd,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [OUT_W-1:0]  rsp_tdata
);

   localparam int ADDR_W = $clog2(HEAP_DEPTH);
   localparam int KID_W  = ADDR_W + 2;
   localparam int RAW_W  = VALUE_W + STATUS_W + CNT_W + 1;

   logic signed [VALUE_W-1:0] heap_mem [HEAP_DEPTH];

   eng_state_type             state_ff, state_in;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic [ADDR_W-1:0]         pos_ff, pos_in;
   logic signed [VALUE_W-1:0] x_ff, x_in;
   status_type                status_ff, status_in;
   logic signed [VALUE_W-1:0] root_ff;
   logic signed [VALUE_W-1:0] rd_a_ff, rd_b_ff;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [OUT_W-1:0]          rsp_data_ff, rsp_data_in;

   logic [ADDR_W-1:0]         rd_addr_a, rd_addr_b;
   logic                      wr_en;
   logic [ADDR_W-1:0]         wr_addr;
   logic signed [VALUE_W-1:0] wr_data;

   logic [ADDR_W-1:0]         parent;
   logic [KID_W-1:0]          kid, kid2, cnt_ext;
   logic                      right_ok, take_right;
   logic signed [VALUE_W-1:0] child_val;
   logic [ADDR_W-1:0]         child_idx;
   logic signed [VALUE_W-1:0] min_out;
   logic [RAW_W-1:0]          raw;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign parent     = ADDR_W'(pos_ff - 1'b1) >> 1;
   assign kid        = {1'b0, pos_ff, 1'b1};
   assign kid2       = KID_W'(kid + 1'b1);
   assign cnt_ext    = KID_W'(cnt_ff);
   assign right_ok   = kid2 < cnt_ext;
   assign take_right = right_ok && (rd_b_ff < rd_a_ff);
   assign child_val  = take_right ? rd_b_ff : rd_a_ff;
   assign child_idx  = take_right ? kid2[ADDR_W-1:0] : kid[ADDR_W-1:0];
   assign min_out    = (cnt_ff != '0) ? root_ff : '0;
   assign raw        = {(cnt_ff == '0), cnt_ff, min_out, status_ff};

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      pos_in       = pos_ff;
      x_in         = x_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      cmd_ready    = 1'b0;
      rd_addr_a    = '0;
      rd_addr_b    = '0;
      wr_en        = 1'b0;
      wr_addr      = pos_ff;
      wr_data      = x_ff;

      case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               cmd_ready = 1'b1;
               status_in = ST_DONE;
               if (cmd.op == OP_PUSH) begin
                  if (cnt_ff == CNT_W'(HEAP_DEPTH)) begin
                     status_in = ST_FULL;
                     state_in  = S_FINISH;
                  end else begin
                     x_in     = cmd.value;
                     pos_in   = cnt_ff[ADDR_W-1:0];
                     cnt_in   = CNT_W'(cnt_ff + 1'b1);
                     state_in = S_UP_RD;
                  end
               end else begin
                  if (cnt_ff == '0) begin
                     status_in = ST_EMPTY;
                     state_in  = S_FINISH;
                  end else begin
                     cnt_in    = CNT_W'(cnt_ff - 1'b1);
                     rd_addr_a = ADDR_W'(cnt_ff - 1'b1);
                     // last entry removed: nothing left to sift
                     state_in  = (cnt_ff == CNT_W'(1)) ? S_FINISH : S_LAST_RD;
                  end
               end
            end
         end
         S_UP_RD: begin
            if (pos_ff == '0) begin
               wr_en    = 1'b1;
               state_in = S_FINISH;
            end else begin
               rd_addr_a = parent;
               state_in  = S_UP_CMP;
            end
         end
         S_UP_CMP: begin
            wr_en = 1'b1;
            if (x_ff < rd_a_ff) begin
               // move the parent down, keep climbing
               wr_data  = rd_a_ff;
               pos_in   = parent;
               state_in = S_UP_RD;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_LAST_RD: begin
            x_in     = rd_a_ff;
            pos_in   = '0;
            state_in = S_DN_RD;
         end
         S_DN_RD: begin
            if (kid >= cnt_ext) begin
               wr_en    = 1'b1;
               state_in = S_FINISH;
            end else begin
               rd_addr_a = kid[ADDR_W-1:0];
               rd_addr_b = kid2[ADDR_W-1:0];
               state_in  = S_DN_CMP;
            end
         end
         S_DN_CMP: begin
            wr_en = 1'b1;
            if (child_val < x_ff) begin
               // move the smaller child up, keep descending
               wr_data  = child_val;
               pos_in   = child_idx;
               state_in = S_DN_RD;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = OUT_W'(raw);
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pos_ff      <= pos_in;
      x_ff        <= x_in;
      status_ff   <= status_in;
      rsp_data_ff <= rsp_data_in;
      if (wr_en && wr_addr == '0) begin
         root_ff <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         heap_mem[wr_addr] <= wr_data;
      end
      rd_a_ff <= heap_mem[rd_addr_a];
      rd_b_ff <= heap_mem[rd_addr_b];
   end

endmodule

[verif/tb_checker.sv]
// Checker for the min-heap queue: predicts each response and compares it with the block's output.
`timescale 1ns / 100ps

module tb_checker
   import bmhq_pkg::*;
#(
   parameter int DEPTH = HEAP_DEPTH_DEF,
   parameter int CNT_W = $clog2(DEPTH + 1),
   parameter int OUT_W = ((VALUE_W + STATUS_W + CNT_W + 1 + 7) / 8) * 8
)
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   input  logic               req_tready,
   input  logic [VALUE_W-1:0] req_tdata,   // value[31:0]
   input  logic               req_tuser,   // operation[0]
   input  logic               rsp_tvalid,
   input  logic               rsp_tready,
   input  logic [OUT_W-1:0]   rsp_tdata,   // status, min_value, entry_count, heap_empty
   output int                 outstanding,
   output int                 mismatches
);

   typedef struct {
      status_type                status;
      logic signed [VALUE_W-1:0] min_value;
      logic [CNT_W-1:0]          entry_count;
      logic                      heap_empty;
   } heap_result_type;

   logic signed [VALUE_W-1:0] heap_mem [DEPTH];
   int                        heap_fill = 0;
   heap_result_type           pending_results [$];
   int                        error_total = 0;

   task automatic report_mismatch(string what, longint got, longint want);
      $display("%0t ns: %s mismatch, got %0d, expected %0d", $time, what, got, want);
      error_total++;
   endtask

   // Apply one operation to the heap copy and return the response it produces.
   function automatic heap_result_type heap_apply(op_type op, logic signed [VALUE_W-1:0] val);
      heap_result_type           res;
      int                        pos;
      int                        up;
      int                        kid;
      logic signed [VALUE_W-1:0] tmp;
      res.status = ST_DONE;
      if (op == OP_PUSH) begin
         if (heap_fill >= DEPTH) begin
            res.status = ST_FULL;
         end else begin
            heap_mem[heap_fill] = val;
            pos = heap_fill;
            heap_fill++;
            while (pos > 0) begin
               up = (pos - 1) / 2;
               if (heap_mem[pos] >= heap_mem[up]) break;
               tmp = heap_mem[pos];
               heap_mem[pos] = heap_mem[up];
               heap_mem[up] = tmp;
               pos = up;
            end
         end
      end else begin
         if (heap_fill == 0) begin
            res.status = ST_EMPTY;
         end else begin
            heap_fill--;
            heap_mem[0] = heap_mem[heap_fill];
            pos = 0;
            kid = 1;
            while (kid < heap_fill) begin
               // take the right child only when strictly smaller
               if (kid + 1 < heap_fill && heap_mem[kid + 1] < heap_mem[kid]) kid++;
               if (heap_mem[kid] >= heap_mem[pos]) break;
               tmp = heap_mem[kid];
               heap_mem[kid] = heap_mem[pos];
               heap_mem[pos] = tmp;
               pos = kid;
               kid = 2 * pos + 1;
            end
         end
      end
      res.min_value   = (heap_fill != 0) ? heap_mem[0] : '0;
      res.entry_count = heap_fill[CNT_W-1:0];
      res.heap_empty  = (heap_fill == 0);
      return res;
   endfunction

   always @(posedge clock) begin
      heap_result_type want;
      heap_result_type got;
      if (!reset) begin
         // check responses first, so one arriving with nothing queued is flagged
         if (rsp_tvalid && rsp_tready) begin
            got.status      = status_type'(rsp_tdata[1:0]);
            got.min_value   = rsp_tdata[2 +: VALUE_W];
            got.entry_count = rsp_tdata[2 + VALUE_W +: CNT_W];
            got.heap_empty  = rsp_tdata[2 + VALUE_W + CNT_W];
            if (pending_results.size() == 0) begin
               report_mismatch("unexpected response, status", got.status, -1);
            end else begin
               want = pending_results.pop_front();
               if (got.status != want.status)
                  report_mismatch("status", got.status, want.status);
               if (got.min_value != want.min_value)
                  report_mismatch("min_value", got.min_value, want.min_value);
               if (got.entry_count != want.entry_count)
                  report_mismatch("entry_count", got.entry_count, want.entry_count);
               if (got.heap_empty != want.heap_empty)
                  report_mismatch("heap_empty", got.heap_empty, want.heap_empty);
            end
         end
         if (req_tvalid && req_tready)
            pending_results.push_back(heap_apply(op_type'(req_tuser), req_tdata));
      end
      outstanding <= pending_results.size();
      mismatches  <= error_total;
   end

endmodule

[verif/tb_top.sv]
// Testbench top for the min-heap queue: clock, reset, request and response traffic, verdict.
`timescale 1ns / 100ps

module tb_top;
   import bmhq_pkg::*;

   localparam int CNT_W       = $clog2(HEAP_DEPTH_DEF + 1);
   localparam int OUT_W       = ((VALUE_W + STATUS_W + CNT_W + 1 + 7) / 8) * 8;
   localparam int RANDOM_OPS  = 1400;
   localparam int QUIET_FIRST = 600;
   localparam int QUIET_LAST  = 900;

   logic               clock = 1'b0;
   logic               reset;
   logic               req_tvalid;
   logic               req_tready;
   logic [VALUE_W-1:0] req_tdata;   // value[31:0]
   logic               req_tuser;   // operation[0]
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [OUT_W-1:0]   rsp_tdata;   // status, min_value, entry_count, heap_empty
   int                 outstanding;
   int                 mismatches;
   int                 sent_count = 0;

   binary_min_heap_queue_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   tb_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .outstanding (outstanding),
      .mismatches  (mismatches)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic logic quiet_window();
      return sent_count >= QUIET_FIRST && sent_count < QUIET_LAST;
   endfunction

   // Response side: stall now and then, never inside the quiet window.
   always @(posedge clock) begin
      rsp_tready <= quiet_window() || ($urandom_range(99) >= 9);
   end

   function automatic logic [VALUE_W-1:0] pick_value();
      case ($urandom_range(9))
         0:       return 32'h8000_0000;
         1:       return 32'h7FFF_FFFF;
         2, 3:    return VALUE_W'(int'($urandom_range(16)) - 8);
         default: return $urandom();
      endcase
   endfunction

   task automatic send_request(op_type op, logic [VALUE_W-1:0] val);
      if (!quiet_window() && $urandom_range(99) < 9) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= val;
      do @(posedge clock); while (!req_tready);
      sent_count++;
   endtask

   // Hold the request side until every queued response has come back.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic send_run(int count, int push_pct);
      repeat (count) begin
         if ($urandom_range(99) < push_pct) send_request(OP_PUSH, pick_value());
         else send_request(OP_POP, $urandom());
      end
   endtask

   initial begin
      int random_sent;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tuser  = OP_PUSH;
      req_tdata  = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: empty pop, extremes, equal keys, pop to empty
      send_request(OP_POP, 32'h0);
      send_request(OP_PUSH, 32'h0000_0000);
      send_request(OP_PUSH, 32'h7FFF_FFFF);
      send_request(OP_PUSH, 32'h8000_0000);
      send_request(OP_PUSH, 32'hFFFF_FFFF);
      send_request(OP_PUSH, 32'hFFFF_FFFF);
      send_request(OP_PUSH, 32'h0000_0001);
      send_request(OP_PUSH, 32'h0000_0000);
      repeat (7) send_request(OP_POP, 32'hFFFF_FFFF);
      send_request(OP_POP, 32'h0);
      send_request(OP_PUSH, 32'd5);
      send_request(OP_PUSH, 32'd5);
      send_request(OP_POP, 32'h0);
      send_request(OP_POP, 32'h0);
      wait_drained();

      // fill past full, then drain past empty
      send_run(70, 100);
      send_run(70, 0);
      random_sent = 140;

      while (random_sent < RANDOM_OPS) begin
         int run_len;
         int push_pct;
         run_len = $urandom_range(40, 160);
         case ($urandom_range(2))
            0:       push_pct = 85;
            1:       push_pct = 15;
            default: push_pct = 50;
         endcase
         send_run(run_len, push_pct);
         random_sent += run_len;
         if ($urandom_range(3) == 0) wait_drained();
      end

      wait_drained();
      repeat (40) @(posedge clock);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule
